// ----- rtl/csp_pkg.sv -----
// ----------------------------------------------------------------------------
// csp_pkg - shared types and constants for the circle spiral point block
// Holds the CORDIC arctangent table, register indexes and the stage record.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [2:0] REG_TOTAL  = 3'd0;
  localparam logic [2:0] REG_RADIUS = 3'd1;
  localparam logic [2:0] REG_DRIFT  = 3'd2;
  localparam logic [2:0] REG_START_Y = 3'd3;
  localparam logic [2:0] REG_START_Z = 3'd4;

  function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
    case (i)
      5'd0:  atan_turn = 34'sh020000000;
      5'd1:  atan_turn = 34'sh012E4051E;
      5'd2:  atan_turn = 34'sh009FB385B;
      5'd3:  atan_turn = 34'sh0051111D4;
      5'd4:  atan_turn = 34'sh0028B0D43;
      5'd5:  atan_turn = 34'sh00145D7E1;
      5'd6:  atan_turn = 34'sh000A2F61E;
      5'd7:  atan_turn = 34'sh000517C55;
      5'd8:  atan_turn = 34'sh00028BE53;
      5'd9:  atan_turn = 34'sh000145F2F;
      5'd10: atan_turn = 34'sh0000A2F98;
      5'd11: atan_turn = 34'sh0000517CC;
      5'd12: atan_turn = 34'sh000028BE6;
      5'd13: atan_turn = 34'sh0000145F3;
      5'd14: atan_turn = 34'sh00000A2FA;
      5'd15: atan_turn = 34'sh00000517D;
      5'd16: atan_turn = 34'sh0000028BE;
      5'd17: atan_turn = 34'sh00000145F;
      5'd18: atan_turn = 34'sh000000A30;
      5'd19: atan_turn = 34'sh000000518;
      5'd20: atan_turn = 34'sh00000028C;
      5'd21: atan_turn = 34'sh000000146;
      5'd22: atan_turn = 34'sh0000000A3;
      5'd23: atan_turn = 34'sh000000051;
      5'd24: atan_turn = 34'sh000000029;
      5'd25: atan_turn = 34'sh000000014;
      5'd26: atan_turn = 34'sh00000000A;
      5'd27: atan_turn = 34'sh000000005;
      5'd28: atan_turn = 34'sh000000003;
      5'd29: atan_turn = 34'sh000000001;
      default: atan_turn = 34'sh000000000;
    endcase
  endfunction

  // Rotation vector travelling down a CORDIC chain
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               flip;
  } rot_t;

  // Side data carried beside the rotation: the per-item fields
  typedef struct packed {
    logic [15:0]        tick;
    logic [16:0]        rem;
    logic signed [32:0] u;
  } side_t;

endpackage

// ----- rtl/csp_divider.sv -----
// ----------------------------------------------------------------------------
// csp_divider - pipelined restoring divider, one quotient bit per cell
// Forms floor(num / den) with a row of identical subtract-and-shift cells.
// ----------------------------------------------------------------------------
module csp_divider #(
  parameter int NUM_W = 39,
  parameter int DEN_W = 16,
  parameter int SIDE_W = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quot,
  output logic [SIDE_W-1:0] side_out
);

  logic [NUM_W:0]    vld;
  logic [DEN_W:0]    rem_s [NUM_W+1];
  logic [NUM_W-1:0]  q_s   [NUM_W+1];
  logic [NUM_W-1:0]  n_s   [NUM_W+1];
  logic [DEN_W-1:0]  d_s   [NUM_W+1];
  logic [SIDE_W-1:0] sd_s  [NUM_W+1];

  assign vld[0]   = in_valid;
  assign rem_s[0] = '0;
  assign q_s[0]   = '0;
  assign n_s[0]   = num;
  assign d_s[0]   = den;
  assign sd_s[0]  = side_in;

  for (genvar k = 0; k < NUM_W; k++) begin : g_cell
    logic [DEN_W+1:0] trial;
    logic [DEN_W+1:0] diff;
    assign trial = {rem_s[k], n_s[k][NUM_W-1]};
    assign diff  = trial - {2'b00, d_s[k]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (advance) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        if (!diff[DEN_W+1]) begin
          rem_s[k+1] <= diff[DEN_W:0];
        end else begin
          rem_s[k+1] <= trial[DEN_W:0];
        end
        q_s[k+1]  <= {q_s[k][NUM_W-2:0], ~diff[DEN_W+1]};
        n_s[k+1]  <= {n_s[k][NUM_W-2:0], 1'b0};
        d_s[k+1]  <= d_s[k];
        sd_s[k+1] <= sd_s[k];
      end
    end
  end

  assign out_valid = vld[NUM_W];
  assign quot      = q_s[NUM_W];
  assign side_out  = sd_s[NUM_W];

endmodule

// ----- rtl/csp_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// csp_cordic_cell - one CORDIC rotation step
// Rotates the vector by the table angle of its step and registers it.
// ----------------------------------------------------------------------------
module csp_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          advance,
  input  csp_pkg::rot_t rot_in,
  output csp_pkg::rot_t rot_out
);

  localparam logic [4:0] STEP_IDX = 5'(STEP);

  logic signed [33:0] dx;
  logic signed [33:0] dy;

  assign dx = rot_in.y >>> STEP;
  assign dy = rot_in.x >>> STEP;

  always_ff @(posedge clk) begin
    if (advance) begin
      rot_out.flip <= rot_in.flip;
      if (!rot_in.z[33]) begin
        rot_out.x <= rot_in.x - dx;
        rot_out.y <= rot_in.y + dy;
        rot_out.z <= rot_in.z - csp_pkg::atan_turn(STEP_IDX);
      end else begin
        rot_out.x <= rot_in.x + dx;
        rot_out.y <= rot_in.y - dy;
        rot_out.z <= rot_in.z + csp_pkg::atan_turn(STEP_IDX);
      end
    end
  end

endmodule

// ----- rtl/csp_sincos.sv -----
// ----------------------------------------------------------------------------
// csp_sincos - pipelined sine and cosine of a turn angle
// Folds the angle into the right half plane and runs a chain of cells.
// ----------------------------------------------------------------------------
module csp_sincos #(
  parameter int SIDE_W = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               in_valid,
  input  logic [31:0]        angle,
  input  logic [SIDE_W-1:0]  side_in,
  output logic               out_valid,
  output logic signed [33:0] cos_q30,
  output logic signed [33:0] sin_q30,
  output logic [SIDE_W-1:0]  side_out
);

  localparam int N = csp_pkg::CORDIC_STEPS;

  csp_pkg::rot_t     rot [N+1];
  logic [N:0]        vld;
  logic [SIDE_W-1:0] sd [N+1];
  logic [31:0]       shifted;
  logic              fl;
  logic [31:0]       a_f;

  assign shifted = angle + 32'h4000_0000;
  assign fl      = shifted[31];
  assign a_f     = fl ? angle + 32'h8000_0000 : angle;

  assign rot[0].x    = csp_pkg::CORDIC_GAIN;
  assign rot[0].y    = '0;
  assign rot[0].z    = {{2{a_f[31]}}, a_f};
  assign rot[0].flip = fl;
  assign vld[0]      = in_valid;
  assign sd[0]       = side_in;

  for (genvar i = 0; i < N; i++) begin : g_step
    csp_cordic_cell #(.STEP(i)) u_cell (
      .clk(clk), .advance(advance), .rot_in(rot[i]), .rot_out(rot[i+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (advance) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        sd[i+1] <= sd[i];
      end
    end
  end

  assign out_valid = vld[N];
  assign cos_q30   = rot[N].flip ? -rot[N].x : rot[N].x;
  assign sin_q30   = rot[N].flip ? -rot[N].y : rot[N].y;
  assign side_out  = sd[N];

endmodule

// ----- rtl/circle_spiral_trajectory_point.sv -----
// ----------------------------------------------------------------------------
// circle_spiral_trajectory_point - one point of a cosine-timed circle spiral
// Divider, two CORDIC chains and a short output pipeline, one point per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// input     in   in_valid / in_ready    tick
// output    out  out_valid / out_ready  pos_y, pos_z, remaining, finished
// config    in   cfg_we                 cfg_index, cfg_data
//
// A new tick is taken every cycle unless the output stalls; each point passes
// through 102 register stages, set by the 15 + ANGLE_BITS bit-per-cell
// divider (39 cells), the two 30-cell CORDIC chains in series and three
// single registers (u, products, output).
// The whole pipeline advances as one while the output register is free or
// being taken; a stall at the output holds every stage.
// Reset clears the valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module circle_spiral_trajectory_point #(
  parameter int TURNS = 5,
  parameter int ANGLE_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        tick,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [16:0] remaining,
  output logic               finished,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int NUM_W  = 16 + ANGLE_BITS - 1;
  localparam int SIDE_W = $bits(csp_pkg::side_t);
  localparam int UP = (ANGLE_BITS > 30) ? ANGLE_BITS - 30 : 0;
  localparam int DN = (ANGLE_BITS < 30) ? 30 - ANGLE_BITS : 0;

  logic [15:0]        total_ticks;
  logic [24:0]        radius;
  logic signed [25:0] drift_gain;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total_ticks <= 16'd5000;
      radius      <= 25'd167772;
      drift_gain  <= 26'sd1677722;
      start_y     <= '0;
      start_z     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        csp_pkg::REG_TOTAL:   total_ticks <= cfg_data[15:0];
        csp_pkg::REG_RADIUS:  radius      <= cfg_data[24:0];
        csp_pkg::REG_DRIFT:   drift_gain  <= cfg_data[25:0];
        csp_pkg::REG_START_Y: start_y     <= cfg_data;
        csp_pkg::REG_START_Z: start_z     <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves as one; stall everything while the output is held
  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // Divider: a1 = tick * 2^(ANGLE_BITS-1) / total
  logic [NUM_W-1:0] num;
  logic [15:0]      den;
  csp_pkg::side_t   side0, side1, side2, side3;
  logic             v1, v2, v3;
  logic [NUM_W-1:0] quot;

  assign num = {tick, {(ANGLE_BITS-1){1'b0}}};
  assign den = (total_ticks == 16'd0) ? 16'd1 : total_ticks;
  assign side0.tick = tick;
  assign side0.rem  = 17'({1'b0, total_ticks} - {1'b0, tick});
  assign side0.u    = '0;

  csp_divider #(.NUM_W(NUM_W), .DEN_W(16), .SIDE_W(SIDE_W)) u_div (
    .clk(clk), .rst(rst), .advance(advance), .in_valid(in_valid && in_ready),
    .num(num), .den(den), .side_in(side0),
    .out_valid(v1), .quot(quot), .side_out(side1)
  );

  // First CORDIC: cos of the time angle
  logic [31:0]        ang1;
  logic signed [33:0] c1, s1_unused;
  logic [ANGLE_BITS-1:0] a1;
  assign a1   = quot[ANGLE_BITS-1:0];
  assign ang1 = 32'({a1, {(32-ANGLE_BITS){1'b0}}});

  csp_sincos #(.SIDE_W(SIDE_W)) u_cs1 (
    .clk(clk), .rst(rst), .advance(advance), .in_valid(v1),
    .angle(ang1), .side_in(side1),
    .out_valid(v2), .cos_q30(c1), .sin_q30(s1_unused), .side_out(side2)
  );

  // u = 2^30 - cos, clamped to [0, 2^31]; register it with the turn product
  logic signed [34:0] u_raw;
  logic [31:0]        u_cl;
  csp_pkg::side_t     side2u;
  logic [ANGLE_BITS-1:0] a2;
  logic [39:0]        tu;
  logic               vu;
  logic [ANGLE_BITS-1:0] a2_r;
  assign u_raw = 35'sd1073741824 - 35'(c1);
  assign u_cl  = u_raw[34] ? 32'd0 :
                 (u_raw > 35'sd2147483648) ? 32'h8000_0000 : u_raw[31:0];
  assign tu    = 40'(TURNS) * {8'd0, u_cl};
  assign a2    = ANGLE_BITS'((tu << UP) >> DN);

  always_ff @(posedge clk) begin
    if (rst) begin
      vu <= 1'b0;
    end else if (advance) begin
      vu <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      side2u.tick <= side2.tick;
      side2u.rem  <= side2.rem;
      side2u.u    <= {1'b0, u_cl};
      a2_r        <= a2;
    end
  end
  logic s1_dummy;
  assign s1_dummy = s1_unused[0];

  // Second CORDIC: sin and cos of the phase
  logic [31:0]        ang2;
  logic signed [33:0] c2, s2;
  logic               v3b;
  assign ang2 = 32'({a2_r, {(32-ANGLE_BITS){1'b0}}});

  csp_sincos #(.SIDE_W(SIDE_W)) u_cs2 (
    .clk(clk), .rst(rst), .advance(advance), .in_valid(vu),
    .angle(ang2), .side_in(side2u),
    .out_valid(v3), .cos_q30(c2), .sin_q30(s2), .side_out(side3)
  );

  // Products, one multiplier per term, then round
  logic signed [63:0] py, pz, pd;
  csp_pkg::side_t     side4;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3b <= 1'b0;
    end else if (advance) begin
      v3b <= v3;
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      py    <= 64'(signed'({1'b0, radius})) * 64'(s2) + 64'sd536870912;
      pz    <= 64'(signed'({1'b0, radius})) * 64'(c2) + 64'sd536870912;
      pd    <= 64'(drift_gain) * 64'(side3.u) + 64'sd536870912;
      side4 <= side3;
    end
  end

  // Sums and saturation into the output register
  logic signed [35:0] ysum, zsum;
  assign ysum = 36'(start_y) + 36'(py >>> 30) + 36'(pd >>> 30);
  assign zsum = 36'(start_z) - 36'(pz >>> 30) + 36'(signed'({1'b0, radius}));

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < -36'sd2147483648) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v3b;
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      pos_y     <= sat32(ysum);
      pos_z     <= sat32(zsum);
      remaining <= side4.rem;
      finished  <= side4.rem[16] || (side4.rem == 17'd0) || s1_dummy && 1'b0;
    end
  end

  // Checks
  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready) else $error("ready while stalled");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(pos_y) && $stable(remaining))
    else $error("result changed under stall");
  a_finished_rem: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (finished == (remaining[16] || remaining == 17'd0)))
    else $error("finished flag mismatch");

endmodule
